>>> hdl/dcrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty column range tracker package
// Shared widths, codes, the front-to-back command type and the back-end
// state type.
// ----------------------------------------------------------------------------
package dcrt_pkg;

    localparam int COORD_W = 16;
    localparam int COL_W   = 9;
    localparam int GAP_W   = 6;
    localparam int RSN_W   = 3;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_MAX_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP         = 1'd1;

    localparam logic [COL_W-1:0] PMW_RESET = 9'd200;
    localparam logic [GAP_W-1:0] GAP_RESET = 6'd8;

    // Input operation codes
    localparam logic OP_AREA    = 1'b0;
    localparam logic OP_DISCARD = 1'b1;

    // Result kinds
    localparam logic KIND_FULL    = 1'b0;
    localparam logic KIND_PARTIAL = 1'b1;

    // Full-refresh reason bits
    localparam logic [RSN_W-1:0] REASON_NONE        = 3'b000;
    localparam logic [RSN_W-1:0] REASON_SINGLE_WIDE = 3'b001;
    localparam logic [RSN_W-1:0] REASON_TABLE_FULL  = 3'b010;
    localparam logic [RSN_W-1:0] REASON_TOTAL_WIDE  = 3'b100;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified item as handed from front to back
    typedef struct packed {
        logic             discard;
        logic             has_span;
        logic             too_wide;
        logic             frame_end;
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MOVE,
        BK_ADD,
        BK_SUM,
        BK_EMIT_FULL,
        BK_EMIT_SPAN
    } back_state_t;

endpackage

>>> hdl/dcrt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty area channel
// Valid/ready channel that carries one dirty area or a discard request.
// ----------------------------------------------------------------------------
interface dcrt_in_if
    import dcrt_pkg::*;
    ();

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [COORD_W-1:0] area_left;
    logic signed [COORD_W-1:0] area_right;
    logic signed [COORD_W-1:0] area_top;
    logic signed [COORD_W-1:0] area_bottom;
    logic                      frame_end;

    modport source (
        output valid, op, area_left, area_right, area_top, area_bottom, frame_end,
        input  ready
    );

    modport sink (
        input  valid, op, area_left, area_right, area_top, area_bottom, frame_end,
        output ready
    );

endinterface

>>> hdl/dcrt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refresh result channel
// Valid/ready channel that carries one refresh result.
// ----------------------------------------------------------------------------
interface dcrt_out_if
    import dcrt_pkg::*;
    ();

    logic             valid;
    logic             ready;
    logic             kind;
    logic [COL_W-1:0] span_start;
    logic [COL_W-1:0] span_end;
    logic [RSN_W-1:0] reason;
    logic             last;

    modport source (
        output valid, kind, span_start, span_end, reason, last,
        input  ready
    );

    modport sink (
        input  valid, kind, span_start, span_end, reason, last,
        output ready
    );

endinterface

>>> hdl/dirty_column_range_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty column range tracker
// Gathers the dirty areas of a frame into column spans and reports either a
// partial refresh per span or one full refresh at frame end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Carries
//  in_ch     sink       valid / ready    op, area bounds, frame_end
//  out_ch    source     valid / ready    kind, span_start, span_end, reason, last
//  cfg_*     input      cfg_we only      partial_max_width, merge_gap
//
//  The front end classifies an area in the cycle of its transfer and queues
//  it (two entries), so input is taken while the back end is busy.
//  The back end compares one table slot per cycle and restarts the scan after
//  each merge; at frame end it sums the covered width over the table slots
//  and then emits its results: one full refresh or a partial refresh per span.
//  A stalled output holds the back end; reset clears the span count and
//  pending flags, not the table.
// ----------------------------------------------------------------------------
module dirty_column_range_tracker_top
    import dcrt_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 400,
    parameter int SCREEN_ROWS    = 300,
    parameter int SPAN_SLOTS     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dcrt_in_if.sink              in_ch,
    dcrt_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [COL_W-1:0] pmw_reg;
    logic [GAP_W-1:0] gap_reg;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_cmd;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmw_reg <= PMW_RESET;
            gap_reg <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARTIAL_MAX_WIDTH:
                begin
                    pmw_reg <= cfg_data[COL_W-1:0];
                end
                CFG_MERGE_GAP:
                begin
                    gap_reg <= cfg_data[GAP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    dcrt_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_front (
        .in_ch             (in_ch),
        .partial_max_width (pmw_reg),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_cmd          (push_cmd)
    );

    dcrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    dcrt_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SPAN_SLOTS     (SPAN_SLOTS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .partial_max_width (pmw_reg),
        .merge_gap         (gap_reg),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_pop             (q_pop),
        .out_ch            (out_ch)
    );

endmodule

>>> hdl/dcrt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty column range tracker front end
// Clips each area to the screen, aligns its column span to pixel pairs and
// classifies it for the back end.
// ----------------------------------------------------------------------------
module dcrt_front
    import dcrt_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 400,
    parameter int SCREEN_ROWS    = 300
) (
    dcrt_in_if.sink         in_ch,
    input  logic [COL_W-1:0] partial_max_width,
    output logic            push_valid,
    input  logic            push_ready,
    output cmd_t            push_cmd
);

    localparam logic signed [COORD_W:0] COL_MAX = (COORD_W+1)'(SCREEN_COLUMNS - 1);
    localparam logic signed [COORD_W:0] ROW_MAX = (COORD_W+1)'(SCREEN_ROWS - 1);
    localparam logic [COL_W:0]          COL_LIM = (COL_W+1)'(SCREEN_COLUMNS - 1);

    logic signed [COORD_W:0] left_s;
    logic signed [COORD_W:0] right_s;
    logic signed [COORD_W:0] top_s;
    logic signed [COORD_W:0] bottom_s;
    logic signed [COORD_W:0] cx1;
    logic signed [COORD_W:0] cx2;
    logic signed [COORD_W:0] cy1;
    logic signed [COORD_W:0] cy2;
    logic                    visible;
    logic [COL_W:0]          hi_raw;
    logic [COL_W-1:0]        lo;
    logic [COL_W-1:0]        hi;
    logic [COL_W:0]          width;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;

    always_comb
    begin
        left_s   = {in_ch.area_left[COORD_W-1], in_ch.area_left};
        right_s  = {in_ch.area_right[COORD_W-1], in_ch.area_right};
        top_s    = {in_ch.area_top[COORD_W-1], in_ch.area_top};
        bottom_s = {in_ch.area_bottom[COORD_W-1], in_ch.area_bottom};

        cx1 = left_s[COORD_W] ? '0 : left_s;
        cx2 = (right_s > COL_MAX) ? COL_MAX : right_s;
        cy1 = top_s[COORD_W] ? '0 : top_s;
        cy2 = (bottom_s > ROW_MAX) ? ROW_MAX : bottom_s;

        visible = (cx1 <= cx2) && (cy1 <= cy2);

        // When visible both columns lie on the screen, so their low bits suffice.
        lo     = {cx1[COL_W-1:1], 1'b0};
        hi_raw = {1'b0, cx2[COL_W-1:1], 1'b1};
        hi     = (hi_raw > COL_LIM) ? COL_LIM[COL_W-1:0] : hi_raw[COL_W-1:0];
        width  = {1'b0, hi} - {1'b0, lo} + (COL_W+1)'(1);

        push_cmd.discard   = (in_ch.op == OP_DISCARD);
        push_cmd.has_span  = visible;
        push_cmd.too_wide  = (width >= {1'b0, partial_max_width});
        push_cmd.frame_end = in_ch.frame_end;
        push_cmd.lo        = lo;
        push_cmd.hi        = hi;
    end

endmodule

>>> hdl/dcrt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty column range tracker command queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module dcrt_queue
    import dcrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/dcrt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty column range tracker back end
// Merges spans into the slot table one slot per cycle, sums the covered
// width at frame end and emits the results through an output register.
// ----------------------------------------------------------------------------
module dcrt_back
    import dcrt_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 400,
    parameter int SPAN_SLOTS     = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [COL_W-1:0] partial_max_width,
    input  logic [GAP_W-1:0] merge_gap,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    dcrt_out_if.source       out_ch
);

    localparam int IDX_W = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
    localparam int CNT_W = $clog2(SPAN_SLOTS + 1);
    localparam int COV_W = $clog2(SPAN_SLOTS * SCREEN_COLUMNS + 1);

    back_state_t      state_reg;
    back_state_t      state_next;

    logic [COL_W-1:0] lo_tbl_reg [SPAN_SLOTS];
    logic [COL_W-1:0] hi_tbl_reg [SPAN_SLOTS];
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_addr;
    logic [COL_W-1:0] tbl_lo_wd;
    logic [COL_W-1:0] tbl_hi_wd;
    logic [CNT_W-1:0] rd_addr;
    logic [COL_W-1:0] rd_lo;
    logic [COL_W-1:0] rd_hi;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [COL_W-1:0] lo_reg;
    logic [COL_W-1:0] lo_next;
    logic [COL_W-1:0] hi_reg;
    logic [COL_W-1:0] hi_next;
    logic             fe_reg;
    logic             fe_next;
    logic             full_reg;
    logic             full_next;
    logic [RSN_W-1:0] reason_reg;
    logic [RSN_W-1:0] reason_next;
    logic [COV_W-1:0] covered_reg;
    logic [COV_W-1:0] covered_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_kind_reg;
    logic             out_kind_next;
    logic [COL_W-1:0] out_start_reg;
    logic [COL_W-1:0] out_start_next;
    logic [COL_W-1:0] out_end_reg;
    logic [COL_W-1:0] out_end_next;
    logic [RSN_W-1:0] out_reason_reg;
    logic [RSN_W-1:0] out_reason_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             scan_done;
    logic             hit;
    logic             wide;
    logic             out_free;
    logic             last_slot;

    // The table is read at one place: the last slot while refilling a merged
    // slot, otherwise the slot under the scan index.
    assign rd_addr = (state_reg == BK_MOVE) ? count_reg : idx_reg;
    assign rd_lo   = lo_tbl_reg[rd_addr[IDX_W-1:0]];
    assign rd_hi   = hi_tbl_reg[rd_addr[IDX_W-1:0]];

    assign scan_done = (idx_reg == count_reg);
    assign hit       = ({1'b0, lo_reg} <= ({1'b0, rd_hi} + (COL_W+1)'(merge_gap)))
                    && (({1'b0, hi_reg} + (COL_W+1)'(merge_gap)) >= {1'b0, rd_lo});
    assign wide      = (covered_reg >= COV_W'(partial_max_width));
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign last_slot = (idx_reg == count_reg - CNT_W'(1));

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_kind_reg;
    assign out_ch.span_start = out_start_reg;
    assign out_ch.span_end   = out_end_reg;
    assign out_ch.reason     = out_reason_reg;
    assign out_ch.last       = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !q_cmd.discard)
                begin
                    if (q_cmd.has_span && !q_cmd.too_wide)
                    begin
                        state_next = BK_SCAN;
                    end
                    else if (q_cmd.frame_end)
                    begin
                        state_next = BK_SUM;
                    end
                end
            end
            BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = BK_ADD;
                end
                else if (hit)
                begin
                    state_next = BK_MOVE;
                end
            end
            BK_MOVE:
            begin
                state_next = BK_SCAN;
            end
            BK_ADD:
            begin
                state_next = fe_reg ? BK_SUM : BK_IDLE;
            end
            BK_SUM:
            begin
                if (scan_done)
                begin
                    if (full_reg || wide)
                    begin
                        state_next = BK_EMIT_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_EMIT_SPAN;
                    end
                end
            end
            BK_EMIT_FULL:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_EMIT_SPAN:
            begin
                if (out_free && last_slot)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop           = 1'b0;
        tbl_we          = 1'b0;
        tbl_addr        = idx_reg[IDX_W-1:0];
        tbl_lo_wd       = lo_reg;
        tbl_hi_wd       = hi_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        fe_next         = fe_reg;
        full_next       = full_reg;
        reason_next     = reason_reg;
        covered_next    = covered_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_kind_next   = out_kind_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_reason_next = out_reason_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    fe_next      = q_cmd.frame_end;
                    lo_next      = q_cmd.lo;
                    hi_next      = q_cmd.hi;
                    idx_next     = '0;
                    covered_next = '0;
                    if (q_cmd.discard)
                    begin
                        count_next  = '0;
                        full_next   = 1'b0;
                        reason_next = REASON_NONE;
                    end
                    else if (q_cmd.has_span && q_cmd.too_wide)
                    begin
                        full_next   = 1'b1;
                        reason_next = reason_reg | REASON_SINGLE_WIDE;
                    end
                end
            end
            BK_SCAN:
            begin
                if (!scan_done)
                begin
                    if (hit)
                    begin
                        lo_next    = (rd_lo < lo_reg) ? rd_lo : lo_reg;
                        hi_next    = (rd_hi > hi_reg) ? rd_hi : hi_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            BK_MOVE:
            begin
                // Refill the merged slot from the last slot and rescan.
                tbl_we    = 1'b1;
                tbl_lo_wd = rd_lo;
                tbl_hi_wd = rd_hi;
                idx_next  = '0;
            end
            BK_ADD:
            begin
                if (count_reg == CNT_W'(SPAN_SLOTS))
                begin
                    full_next   = 1'b1;
                    reason_next = reason_reg | REASON_TABLE_FULL;
                end
                else
                begin
                    tbl_we     = 1'b1;
                    tbl_addr   = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                idx_next     = '0;
                covered_next = '0;
            end
            BK_SUM:
            begin
                if (!scan_done)
                begin
                    covered_next = covered_reg + COV_W'(rd_hi) - COV_W'(rd_lo) + COV_W'(1);
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else
                begin
                    if (wide)
                    begin
                        reason_next = reason_reg | REASON_TOTAL_WIDE;
                    end
                    idx_next = '0;
                end
            end
            BK_EMIT_FULL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_FULL;
                    out_start_next  = '0;
                    out_end_next    = '0;
                    out_reason_next = reason_reg;
                    out_last_next   = 1'b1;
                    count_next      = '0;
                    full_next       = 1'b0;
                    reason_next     = REASON_NONE;
                end
            end
            BK_EMIT_SPAN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_PARTIAL;
                    out_start_next  = rd_lo;
                    out_end_next    = rd_hi;
                    out_reason_next = REASON_NONE;
                    out_last_next   = last_slot;
                    idx_next        = idx_reg + CNT_W'(1);
                    if (last_slot)
                    begin
                        count_next  = '0;
                        full_next   = 1'b0;
                        reason_next = REASON_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            fe_reg        <= 1'b0;
            full_reg      <= 1'b0;
            reason_reg    <= REASON_NONE;
            covered_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            fe_reg        <= fe_next;
            full_reg      <= full_next;
            reason_reg    <= reason_next;
            covered_reg   <= covered_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        out_kind_reg   <= out_kind_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_reason_reg <= out_reason_next;
        out_last_reg   <= out_last_next;
        if (tbl_we)
        begin
            lo_tbl_reg[tbl_addr] <= tbl_lo_wd;
            hi_tbl_reg[tbl_addr] <= tbl_hi_wd;
        end
    end

endmodule
